// ----- rtl/lsf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lsf_pkg;

    localparam int COORD_W    = 16;
    localparam int CNT_W      = 13;
    localparam int MAX_POINTS = 4096;
    localparam int SUM_W      = 29;
    localparam int SQ_W       = 44;

    // shared multiplier: signed operands, magnitude shift-add
    localparam int MOP_W      = 44;
    localparam int MUL_CNT_W  = 6;
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MOP_W - 1);

    // products, determinant and numerators
    localparam int PROD_W     = 72;

    // Q16 rounding divider: dividend = |num|*2^17 + den, divisor = 2*den
    localparam int FRAC_W     = 16;
    localparam int RES_W      = 32;
    localparam int DVD_W      = PROD_W + FRAC_W + 2;
    localparam int DVS_W      = PROD_W + 1;
    localparam int DIV_CNT_W  = 7;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DVD_W - 1);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sx;
        logic [SUM_W-1:0] sy;
        logic [SQ_W-1:0]  sxy;
        logic [SQ_W-1:0]  sxx;
    } lsf_sums_t;

endpackage

`default_nettype wire

// ----- rtl/lsf_accum.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lsf_accum (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                take,
    input  wire logic signed [lsf_pkg::COORD_W-1:0]  x_in,
    input  wire logic signed [lsf_pkg::COORD_W-1:0]  y_in,
    input  wire logic                                clear,
    output lsf_pkg::lsf_sums_t                       sums
);

    logic signed [lsf_pkg::COORD_W-1:0]   px_reg;
    logic signed [lsf_pkg::COORD_W-1:0]   py_reg;
    logic                                 pv_reg;
    logic [lsf_pkg::CNT_W-1:0]            count_reg;
    logic [lsf_pkg::SUM_W-1:0]            sx_reg;
    logic [lsf_pkg::SUM_W-1:0]            sy_reg;
    logic [lsf_pkg::SQ_W-1:0]             sxy_reg;
    logic [lsf_pkg::SQ_W-1:0]             sxx_reg;
    logic signed [2*lsf_pkg::COORD_W-1:0] pxy;
    logic signed [2*lsf_pkg::COORD_W-1:0] pxx;
    logic                                 room;

    assign room = (count_reg < lsf_pkg::MAX_CNT);
    assign pxy  = px_reg * py_reg;
    assign pxx  = px_reg * px_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            px_reg <= x_in;
            py_reg <= y_in;
        end
    end

    // count moves at accept, sums in the cycle after from the staged point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg    <= 1'b0;
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxy_reg   <= '0;
            sxx_reg   <= '0;
        end
        else
        begin
            pv_reg <= take && room;
            if (take && room)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (pv_reg)
            begin
                sx_reg  <= sx_reg + {{(lsf_pkg::SUM_W-lsf_pkg::COORD_W){px_reg[lsf_pkg::COORD_W-1]}},
                                     px_reg};
                sy_reg  <= sy_reg + {{(lsf_pkg::SUM_W-lsf_pkg::COORD_W){py_reg[lsf_pkg::COORD_W-1]}},
                                     py_reg};
                sxy_reg <= sxy_reg + {{(lsf_pkg::SQ_W-2*lsf_pkg::COORD_W){pxy[2*lsf_pkg::COORD_W-1]}},
                                      pxy};
                sxx_reg <= sxx_reg + {{(lsf_pkg::SQ_W-2*lsf_pkg::COORD_W){pxx[2*lsf_pkg::COORD_W-1]}},
                                      pxx};
            end
            if (clear)
            begin
                count_reg <= '0;
                sx_reg    <= '0;
                sy_reg    <= '0;
                sxy_reg   <= '0;
                sxx_reg   <= '0;
            end
        end
    end

    assign sums = {count_reg, sx_reg, sy_reg, sxy_reg, sxx_reg};

endmodule

`default_nettype wire

// ----- rtl/lsf_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lsf_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [lsf_pkg::MOP_W-1:0]     a,
    input  wire logic [lsf_pkg::MOP_W-1:0]     b,
    output logic                               done,
    output logic [lsf_pkg::PROD_W-1:0]         prod
);

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_SIGN} mst_t;

    mst_t                              st_reg;
    logic [lsf_pkg::MUL_CNT_W-1:0]     cnt_reg;
    logic [lsf_pkg::MOP_W-1:0]         mcand_reg;
    logic [lsf_pkg::MOP_W-1:0]         hi_reg;
    logic [lsf_pkg::MOP_W-1:0]         lo_reg;
    logic                              neg_reg;
    logic [lsf_pkg::PROD_W-1:0]        prod_reg;
    logic                              done_reg;
    logic [lsf_pkg::MOP_W-1:0]         a_mag;
    logic [lsf_pkg::MOP_W-1:0]         b_mag;
    logic [lsf_pkg::MOP_W:0]           psum;
    logic [2*lsf_pkg::MOP_W-1:0]       mag;

    assign a_mag = a[lsf_pkg::MOP_W-1] ? (~a + 1'b1) : a;
    assign b_mag = b[lsf_pkg::MOP_W-1] ? (~b + 1'b1) : b;
    assign psum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
    assign mag   = {hi_reg, lo_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= a_mag;
            lo_reg    <= b_mag;
            hi_reg    <= '0;
            neg_reg   <= a[lsf_pkg::MOP_W-1] ^ b[lsf_pkg::MOP_W-1];
        end
        else if (st_reg == M_RUN)
        begin
            hi_reg <= psum[lsf_pkg::MOP_W:1];
            lo_reg <= {psum[0], lo_reg[lsf_pkg::MOP_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= M_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            prod_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg <= '0;
                        st_reg  <= M_RUN;
                    end
                end
                M_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == lsf_pkg::MUL_LAST)
                    begin
                        st_reg <= M_SIGN;
                    end
                end
                M_SIGN:
                begin
                    prod_reg <= neg_reg ? (~mag[lsf_pkg::PROD_W-1:0] + 1'b1)
                                        : mag[lsf_pkg::PROD_W-1:0];
                    done_reg <= 1'b1;
                    st_reg   <= M_IDLE;
                end
                default:
                begin
                    st_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

`ifndef SYNTHESIS
    a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> st_reg == M_IDLE)
        else $error("multiplier restarted while running");
`endif

endmodule

`default_nettype wire

// ----- rtl/lsf_qdiv.sv -----
`timescale 1ns / 1ps
`default_nettype none

// round(num * 2^16 / den), ties away from zero, saturated to 32 bits; den > 0
module lsf_qdiv (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [lsf_pkg::PROD_W-1:0]    num,
    input  wire logic [lsf_pkg::PROD_W-1:0]    den,
    output logic                               done,
    output logic [lsf_pkg::RES_W-1:0]          q
);

    typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN, D_FIX} dst_t;

    dst_t                              st_reg;
    logic [lsf_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [lsf_pkg::DVD_W-1:0]         dvd_reg;
    logic [lsf_pkg::DVS_W-1:0]         dvs_reg;
    logic [lsf_pkg::DVS_W-1:0]         rem_reg;
    logic [lsf_pkg::PROD_W-1:0]        den_reg;
    logic                              neg_reg;
    logic [lsf_pkg::RES_W-1:0]         q_reg;
    logic                              done_reg;
    logic [lsf_pkg::PROD_W-1:0]        num_mag;
    logic [lsf_pkg::DVS_W:0]           r2;
    logic [lsf_pkg::DVS_W+1:0]         trial;
    logic                              ge;
    logic [lsf_pkg::RES_W-1:0]         lim;
    logic                              sat;
    logic [lsf_pkg::RES_W-1:0]         qmag;

    assign num_mag = num[lsf_pkg::PROD_W-1] ? (~num + 1'b1) : num;
    assign r2      = {rem_reg, dvd_reg[lsf_pkg::DVD_W-1]};
    assign trial   = {1'b0, r2} - {2'b00, dvs_reg};
    assign ge      = !trial[lsf_pkg::DVS_W+1];
    assign lim     = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign sat     = (|dvd_reg[lsf_pkg::DVD_W-1:lsf_pkg::RES_W])
                     || (dvd_reg[lsf_pkg::RES_W-1:0] > lim);
    assign qmag    = sat ? lim : dvd_reg[lsf_pkg::RES_W-1:0];

    // dvd_reg holds the dividend and takes quotient bits in from the bottom
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    neg_reg <= num[lsf_pkg::PROD_W-1];
                    den_reg <= den;
                    dvs_reg <= {den, 1'b0};
                    rem_reg <= '0;
                    dvd_reg <= {{(lsf_pkg::DVD_W-lsf_pkg::PROD_W-lsf_pkg::FRAC_W-1){1'b0}},
                                num_mag, {(lsf_pkg::FRAC_W+1){1'b0}}};
                end
            end
            D_PREP:
            begin
                dvd_reg <= dvd_reg + {{(lsf_pkg::DVD_W-lsf_pkg::PROD_W){1'b0}}, den_reg};
            end
            D_RUN:
            begin
                rem_reg <= ge ? trial[lsf_pkg::DVS_W-1:0] : r2[lsf_pkg::DVS_W-1:0];
                dvd_reg <= {dvd_reg[lsf_pkg::DVD_W-2:0], ge};
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= D_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        st_reg <= D_PREP;
                    end
                end
                D_PREP:
                begin
                    cnt_reg <= '0;
                    st_reg  <= D_RUN;
                end
                D_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == lsf_pkg::DIV_LAST)
                    begin
                        st_reg <= D_FIX;
                    end
                end
                D_FIX:
                begin
                    q_reg    <= neg_reg ? (~qmag + 1'b1) : qmag;
                    done_reg <= 1'b1;
                    st_reg   <= D_IDLE;
                end
                default:
                begin
                    st_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

`ifndef SYNTHESIS
    a_div_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == D_RUN |-> rem_reg < dvs_reg)
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ----- rtl/least_squares_line_fit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// input     start (taken if !busy) x_coord, y_coord, last_point
// result    done (one-cycle pulse) slope, intercept, fit_ok, points_used
//
// Points that are not last are taken every cycle; busy stays low.
// A last point raises busy: a flush state, then six products on the shared shift-add
// multiplier and two divisions.
// A degenerate set ends after the determinant.
// The result pulse, the clearing of the sums and the fall of busy share one cycle.
// Reset is asynchronous, active low; the receiver cannot stall.
module least_squares_line_fit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [lsf_pkg::COORD_W-1:0]  x_coord,
    input  wire logic signed [lsf_pkg::COORD_W-1:0]  y_coord,
    input  wire logic                                last_point,
    output logic                                     done,
    output logic signed [lsf_pkg::RES_W-1:0]         slope,
    output logic signed [lsf_pkg::RES_W-1:0]         intercept,
    output logic                                     fit_ok,
    output logic [lsf_pkg::CNT_W-1:0]                points_used
);

    typedef enum logic [2:0] {S_IDLE, S_FLUSH, S_MUL, S_CHECK, S_DIV} state_t;
    typedef enum logic [2:0] {ST_DEN_P, ST_DEN_Q, ST_NA_P, ST_NA_Q, ST_NB_P, ST_NB_Q} step_t;

    state_t                          state_reg;
    step_t                           step_reg;
    logic                            mul_start_reg;
    logic                            div_start_reg;
    logic                            div_b_reg;
    logic [lsf_pkg::PROD_W-1:0]      acc_reg;
    logic [lsf_pkg::PROD_W-1:0]      den_reg;
    logic [lsf_pkg::PROD_W-1:0]      num_reg;
    logic [lsf_pkg::RES_W-1:0]       slope_reg;
    logic [lsf_pkg::RES_W-1:0]       intercept_reg;
    logic                            fit_ok_reg;
    logic [lsf_pkg::CNT_W-1:0]       points_reg;
    logic                            done_reg;

    lsf_pkg::lsf_sums_t              sums;
    logic                            take;
    logic                            clear;
    logic                            ok;
    logic [lsf_pkg::MOP_W-1:0]       op_a;
    logic [lsf_pkg::MOP_W-1:0]       op_b;
    logic [lsf_pkg::MOP_W-1:0]       ext_n;
    logic [lsf_pkg::MOP_W-1:0]       ext_sx;
    logic [lsf_pkg::MOP_W-1:0]       ext_sy;
    logic                            mul_done;
    logic [lsf_pkg::PROD_W-1:0]      mul_prod;
    logic [lsf_pkg::PROD_W-1:0]      diff;
    logic                            div_done;
    logic [lsf_pkg::RES_W-1:0]       div_q;

    assign busy = (state_reg != S_IDLE);
    assign take = start && !busy;

    lsf_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .x_in  (x_coord),
        .y_in  (y_coord),
        .clear (clear),
        .sums  (sums)
    );

    assign ext_n  = {{(lsf_pkg::MOP_W-lsf_pkg::CNT_W){1'b0}}, sums.count};
    assign ext_sx = {{(lsf_pkg::MOP_W-lsf_pkg::SUM_W){sums.sx[lsf_pkg::SUM_W-1]}}, sums.sx};
    assign ext_sy = {{(lsf_pkg::MOP_W-lsf_pkg::SUM_W){sums.sy[lsf_pkg::SUM_W-1]}}, sums.sy};

    always_comb
    begin
        unique case (step_reg)
            ST_DEN_P: begin op_a = ext_n;    op_b = sums.sxx; end
            ST_DEN_Q: begin op_a = ext_sx;   op_b = ext_sx;   end
            ST_NA_P:  begin op_a = ext_n;    op_b = sums.sxy; end
            ST_NA_Q:  begin op_a = ext_sx;   op_b = ext_sy;   end
            ST_NB_P:  begin op_a = sums.sxx; op_b = ext_sy;   end
            ST_NB_Q:  begin op_a = ext_sx;   op_b = sums.sxy; end
            default:  begin op_a = '0;       op_b = '0;       end
        endcase
    end

    lsf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (op_a),
        .b     (op_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    lsf_qdiv u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .q     (div_q)
    );

    assign diff  = acc_reg - mul_prod;
    // at least two points and a positive determinant
    assign ok    = (|sums.count[lsf_pkg::CNT_W-1:1]) && !den_reg[lsf_pkg::PROD_W-1]
                   && (den_reg != '0);
    assign clear = ((state_reg == S_CHECK) && !ok)
                   || ((state_reg == S_DIV) && div_done && div_b_reg);

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_MUL) && mul_done)
        begin
            unique case (step_reg)
                ST_DEN_P, ST_NA_P, ST_NB_P: acc_reg <= mul_prod;
                ST_DEN_Q:                   den_reg <= diff;
                default:                    num_reg <= diff;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_DEN_P;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            div_b_reg     <= 1'b0;
            slope_reg     <= '0;
            intercept_reg <= '0;
            fit_ok_reg    <= 1'b0;
            points_reg    <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            done_reg      <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take && last_point)
                    begin
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH:
                begin
                    div_b_reg     <= 1'b0;
                    step_reg      <= ST_DEN_P;
                    mul_start_reg <= 1'b1;
                    state_reg     <= S_MUL;
                end
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        unique case (step_reg)
                            ST_DEN_P:
                            begin
                                step_reg      <= ST_DEN_Q;
                                mul_start_reg <= 1'b1;
                            end
                            ST_NA_P:
                            begin
                                step_reg      <= ST_NA_Q;
                                mul_start_reg <= 1'b1;
                            end
                            ST_NB_P:
                            begin
                                step_reg      <= ST_NB_Q;
                                mul_start_reg <= 1'b1;
                            end
                            ST_DEN_Q:
                            begin
                                state_reg <= S_CHECK;
                            end
                            default:
                            begin
                                div_start_reg <= 1'b1;
                                state_reg     <= S_DIV;
                            end
                        endcase
                    end
                end
                S_CHECK:
                begin
                    if (ok)
                    begin
                        step_reg      <= ST_NA_P;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL;
                    end
                    else
                    begin
                        slope_reg     <= '0;
                        intercept_reg <= '0;
                        fit_ok_reg    <= 1'b0;
                        points_reg    <= sums.count;
                        done_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (!div_b_reg)
                        begin
                            slope_reg     <= div_q;
                            div_b_reg     <= 1'b1;
                            step_reg      <= ST_NB_P;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_MUL;
                        end
                        else
                        begin
                            intercept_reg <= div_q;
                            fit_ok_reg    <= 1'b1;
                            points_reg    <= sums.count;
                            done_reg      <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign slope       = slope_reg;
    assign intercept   = intercept_reg;
    assign fit_ok      = fit_ok_reg;
    assign points_used = points_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result issued while fit still running");

    a_bad_fit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !fit_ok_reg |-> slope_reg == '0 && intercept_reg == '0)
        else $error("degenerate fit carries nonzero fields");

    a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
        take && last_point |=> state_reg == S_FLUSH)
        else $error("last item did not start a fit");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> sums.count == '0 && !done_reg == 1'b0)
        else $error("sums not cleared with the result");
`endif

endmodule

`default_nettype wire
